// File: rtl/balance_inner_loop_controller_macros.svh
// Assertion macros used by the balance controller top level.
// Included by the top level; depends on nothing else.
`ifndef BALANCE_INNER_LOOP_CONTROLLER_MACROS_SVH
`define BALANCE_INNER_LOOP_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLIC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLIC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/blic_pkg.sv
// Types, constants and the microcode store of the balance controller.
// Used by the sequencer, the datapath and the top level; no dependencies.
package blic_pkg;

  localparam int DEF_FILTER_ORDER      = 2;
  localparam int DEF_SAT_TIMEOUT_TICKS = 256;

  // 0.95 in Q2.12
  localparam logic [13:0] SAT_THRESHOLD = 14'd3891;

  localparam logic signed [23:0] RST_GAIN  = 24'sd65536;
  localparam logic [12:0]        RST_LIMIT = 13'd4096;
  localparam logic [13:0]        RST_TIP   = 14'd3482;

  localparam int UPC_W = 3;

  typedef enum logic [2:0] {
    REG_NUM_B0       = 3'd0,
    REG_NUM_B1       = 3'd1,
    REG_NUM_B2       = 3'd2,
    REG_DEN_A1       = 3'd3,
    REG_DEN_A2       = 3'd4,
    REG_LOOP_GAIN    = 3'd5,
    REG_OUTPUT_LIMIT = 3'd6,
    REG_TILT_LIMIT   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_PAUSED  = 2'd1,
    CAUSE_TIP     = 2'd2,
    CAUSE_TIMEOUT = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    PATH_IDLE,
    PATH_PAUSE,
    PATH_ARM,
    PATH_TIP,
    PATH_DRIVE
  } path_t;

  typedef enum logic [1:0] {
    OP_DECIDE,
    OP_MAC,
    OP_GAIN,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    CO_B0,
    CO_B1,
    CO_B2,
    CO_A1,
    CO_A2,
    CO_GAIN
  } coef_sel_t;

  typedef enum logic [2:0] {
    DS_E0,
    DS_E1,
    DS_E2,
    DS_Y1,
    DS_Y2,
    DS_V
  } data_sel_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_SKIP_FILTER,
    COND_LOW_ORDER
  } cond_t;

  typedef struct packed {
    op_t              op;
    coef_sel_t        coef_sel;
    data_sel_t        data_sel;
    logic             neg;
    logic             first;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    logic   en;
    logic   busy;
    ucode_t word;
  } seq_ctrl_t;

  typedef struct packed {
    logic skip_filter;
  } dp_status_t;

  typedef struct packed {
    logic signed [23:0] num_b0;
    logic signed [23:0] num_b1;
    logic signed [23:0] num_b2;
    logic signed [23:0] den_a1;
    logic signed [23:0] den_a2;
    logic signed [23:0] loop_gain;
    logic        [12:0] output_limit;
    logic        [13:0] tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] tilt_angle;
    logic signed [15:0] tilt_reference;
    logic               running;
    logic               arm_request;
  } in_item_t;

  typedef struct packed {
    logic signed [13:0] duty;
    logic               motor_enable;
    logic               armed_flag;
    cause_t             disarm_cause;
  } result_t;

  // Control store. Step 0 sorts the sample and jumps straight to the
  // finishing step when nothing is to be filtered; step 3 leaves out the
  // second-order taps for a first-order filter.
  function automatic ucode_t ucode_fetch(input logic [UPC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_FINISH, coef_sel: CO_B0, data_sel: DS_E0, neg: 1'b0, first: 1'b0,
          cond: COND_NONE, target: '0, last: 1'b1};
    case (pc)
      3'd0: begin
        w.op     = OP_DECIDE;
        w.cond   = COND_SKIP_FILTER;
        w.target = 3'd7;
        w.last   = 1'b0;
      end
      3'd1: begin
        w.op       = OP_MAC;
        w.coef_sel = CO_B0;
        w.data_sel = DS_E0;
        w.first    = 1'b1;
        w.last     = 1'b0;
      end
      3'd2: begin
        w.op       = OP_MAC;
        w.coef_sel = CO_B1;
        w.data_sel = DS_E1;
        w.last     = 1'b0;
      end
      3'd3: begin
        w.op       = OP_MAC;
        w.coef_sel = CO_A1;
        w.data_sel = DS_Y1;
        w.neg      = 1'b1;
        w.cond     = COND_LOW_ORDER;
        w.target   = 3'd6;
        w.last     = 1'b0;
      end
      3'd4: begin
        w.op       = OP_MAC;
        w.coef_sel = CO_B2;
        w.data_sel = DS_E2;
        w.last     = 1'b0;
      end
      3'd5: begin
        w.op       = OP_MAC;
        w.coef_sel = CO_A2;
        w.data_sel = DS_Y2;
        w.neg      = 1'b1;
        w.last     = 1'b0;
      end
      3'd6: begin
        w.op       = OP_GAIN;
        w.coef_sel = CO_GAIN;
        w.data_sel = DS_V;
        w.last     = 1'b0;
      end
      default: begin
        w.op   = OP_FINISH;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/balance_inner_loop_controller.sv
// Top level of the balance inner-loop controller: ports, configuration
// registers and the output register. Depends on blic_pkg, blic_sequencer,
// blic_datapath and the macros header.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    tilt_angle, tilt_reference, running, arm_request
//   out      out_valid / out_ready  duty, motor_enable, armed_flag, disarm_cause
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A driven sample runs the microcode steps in turn through the single shared multiplier,
// leaving out the second-order taps for a first-order filter; any other sample jumps
// from the sorting step to the finishing step. One sample is in work at a time.
// Reset is synchronous and leaves the block disarmed with default coefficients.
// The last step waits while the output register holds an untaken word;
// a new sample may be taken as soon as the previous one has left the sequencer.
`include "balance_inner_loop_controller_macros.svh"

module balance_inner_loop_controller #(
  parameter int FILTER_ORDER      = blic_pkg::DEF_FILTER_ORDER,
  parameter int SAT_TIMEOUT_TICKS = blic_pkg::DEF_SAT_TIMEOUT_TICKS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_tilt_angle,
  input  logic signed [15:0] in_tilt_reference,
  input  logic               in_running,
  input  logic               in_arm_request,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_duty,
  output logic               out_motor_enable,
  output logic               out_armed_flag,
  output logic        [1:0]  out_disarm_cause,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [23:0] cfg_data
);
  import blic_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  result_t    res_r;
  result_t    result;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       out_free;
  logic       commit;
  in_item_t   item;
  seq_ctrl_t  ctrl;
  dp_status_t status;
  logic       drive_word;
  logic       disarm_word;
  logic       duty_quiet;
  logic       duty_in_clamp;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !ctrl.busy;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign item.tilt_angle     = in_tilt_angle;
  assign item.tilt_reference = in_tilt_reference;
  assign item.running        = in_running;
  assign item.arm_request    = in_arm_request;

  blic_sequencer #(
    .FILTER_ORDER(FILTER_ORDER)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire),
    .out_free(out_free),
    .status  (status),
    .ctrl    (ctrl)
  );

  blic_datapath #(
    .FILTER_ORDER     (FILTER_ORDER),
    .SAT_TIMEOUT_TICKS(SAT_TIMEOUT_TICKS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_fire),
    .item  (item),
    .cfg   (cfg_r),
    .ctrl  (ctrl),
    .status(status),
    .commit(commit),
    .result(result)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_NUM_B0:       cfg_nxt.num_b0       = cfg_data;
        REG_NUM_B1:       cfg_nxt.num_b1       = cfg_data;
        REG_NUM_B2:       cfg_nxt.num_b2       = cfg_data;
        REG_DEN_A1:       cfg_nxt.den_a1       = cfg_data;
        REG_DEN_A2:       cfg_nxt.den_a2       = cfg_data;
        REG_LOOP_GAIN:    cfg_nxt.loop_gain    = cfg_data;
        REG_OUTPUT_LIMIT: cfg_nxt.output_limit = cfg_data[12:0];
        REG_TILT_LIMIT:   cfg_nxt.tilt_limit   = cfg_data[13:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_b0       <= '0;
      cfg_r.num_b1       <= '0;
      cfg_r.num_b2       <= '0;
      cfg_r.den_a1       <= '0;
      cfg_r.den_a2       <= '0;
      cfg_r.loop_gain    <= RST_GAIN;
      cfg_r.output_limit <= RST_LIMIT;
      cfg_r.tilt_limit   <= RST_TIP;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = res_r.duty;
  assign out_motor_enable = res_r.motor_enable;
  assign out_armed_flag   = res_r.armed_flag;
  assign out_disarm_cause = res_r.disarm_cause;

  assign drive_word    = out_valid && out_motor_enable;
  assign disarm_word   = out_valid && out_disarm_cause != CAUSE_NONE;
  assign duty_quiet    = !out_armed_flag && !out_motor_enable && out_duty == 14'sd0;
  assign duty_in_clamp = out_duty <= $signed({1'b0, cfg_r.output_limit})
                      && out_duty >= -$signed({1'b0, cfg_r.output_limit});

  // Driving the motors always means the block is still armed.
  `BLIC_ASSERT_IMP(a_enable_armed, clk, rst_n, drive_word, out_armed_flag, "drive while disarmed")

  // A disarm word carries no drive.
  `BLIC_ASSERT_IMP(a_disarm_quiet, clk, rst_n, disarm_word, duty_quiet, "disarm word drives")

  // A driven duty stays inside the configured clamp.
  `BLIC_ASSERT_IMP(a_duty_clamp, clk, rst_n, drive_word, duty_in_clamp, "duty outside clamp")

  // Taking a sample makes the sequencer busy on the next cycle.
  `BLIC_ASSERT_NXT(a_start_busy, clk, rst_n, in_fire, !in_ready, "sequencer did not start")

endmodule

// File: rtl/blic_sequencer.sv
// Microcode sequencer: step counter, control store fetch and jumps.
// Depends on blic_pkg.
module blic_sequencer #(
  parameter int FILTER_ORDER = blic_pkg::DEF_FILTER_ORDER
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   out_free,
  input  blic_pkg::dp_status_t   status,
  output blic_pkg::seq_ctrl_t    ctrl
);
  import blic_pkg::*;

  logic [UPC_W-1:0] pc_r, pc_nxt;
  logic             busy_r, busy_nxt;
  ucode_t           word;
  logic             stall;
  logic             en;
  logic             jump;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    word  = ucode_fetch(pc_r);
    // The finishing step waits while the output register holds a word that is not taken.
    stall = word.last && !out_free;
    en    = busy_r && !stall;
    case (word.cond)
      COND_SKIP_FILTER: jump = status.skip_filter;
      COND_LOW_ORDER:   jump = (FILTER_ORDER < 2);
      default:          jump = 1'b0;
    endcase
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (en) begin
      if (word.last) begin
        busy_nxt = 1'b0;
      end else if (jump) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
    ctrl.en   = en;
    ctrl.busy = busy_r;
    ctrl.word = word;
  end

endmodule

// File: rtl/blic_datapath.sv
// Datapath: shared multiplier and accumulator, histories, arming state
// and the saturation counter. Depends on blic_pkg.
module blic_datapath #(
  parameter int FILTER_ORDER      = blic_pkg::DEF_FILTER_ORDER,
  parameter int SAT_TIMEOUT_TICKS = blic_pkg::DEF_SAT_TIMEOUT_TICKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  blic_pkg::in_item_t    item,
  input  blic_pkg::cfg_t        cfg,
  input  blic_pkg::seq_ctrl_t   ctrl,
  output blic_pkg::dp_status_t  status,
  output logic                  commit,
  output blic_pkg::result_t     result
);
  import blic_pkg::*;

  localparam int CNT_W = (SAT_TIMEOUT_TICKS < 2) ? 1 : $clog2(SAT_TIMEOUT_TICKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SAT_TIMEOUT_TICKS);

  in_item_t           item_r;
  path_t              path_r, path_nxt;
  logic signed [15:0] e0_r, e0_nxt;
  logic signed [15:0] e1_r, e1_nxt, e2_r, e2_nxt;
  logic signed [13:0] y1_r, y1_nxt, y2_r, y2_nxt;
  logic signed [42:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               armed_r, armed_nxt;

  logic        [16:0] angle_abs;
  logic signed [16:0] diff;
  logic signed [23:0] coef;
  logic signed [26:0] opnd;
  logic signed [50:0] prod;
  logic signed [42:0] term;
  logic signed [42:0] lim;
  logic signed [13:0] y;
  logic        [13:0] y_abs;
  logic               over;

  assign prod = coef * opnd;

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
    if (ctrl.en && ctrl.word.op == OP_DECIDE) begin
      path_r <= path_nxt;
      e0_r   <= e0_nxt;
    end
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r    <= '0;
      e2_r    <= '0;
      y1_r    <= '0;
      y2_r    <= '0;
      cnt_r   <= '0;
      armed_r <= 1'b0;
    end else begin
      e1_r    <= e1_nxt;
      e2_r    <= e2_nxt;
      y1_r    <= y1_nxt;
      y2_r    <= y2_nxt;
      cnt_r   <= cnt_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Sorting of the sample and the saturated error.
  always_comb begin
    angle_abs = item_r.tilt_angle[15] ? 17'(-{1'b1, item_r.tilt_angle})
                                      : {1'b0, item_r.tilt_angle};
    diff = {item_r.tilt_reference[15], item_r.tilt_reference}
         - {item_r.tilt_angle[15], item_r.tilt_angle};
    if (diff[16] != diff[15]) begin
      e0_nxt = diff[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      e0_nxt = diff[15:0];
    end
    if (!item_r.running) begin
      path_nxt = armed_r ? PATH_PAUSE : PATH_IDLE;
    end else if (!armed_r) begin
      path_nxt = item_r.arm_request ? PATH_ARM : PATH_IDLE;
    end else if (angle_abs > {3'b000, cfg.tilt_limit}) begin
      path_nxt = PATH_TIP;
    end else begin
      path_nxt = PATH_DRIVE;
    end
    status.skip_filter = (path_nxt != PATH_DRIVE);
  end

  // Operand selection and accumulation.
  always_comb begin
    case (ctrl.word.coef_sel)
      CO_B0:   coef = cfg.num_b0;
      CO_B1:   coef = cfg.num_b1;
      CO_B2:   coef = cfg.num_b2;
      CO_A1:   coef = cfg.den_a1;
      CO_A2:   coef = cfg.den_a2;
      CO_GAIN: coef = cfg.loop_gain;
      default: coef = '0;
    endcase
    case (ctrl.word.data_sel)
      DS_E0:   opnd = 27'(e0_r);
      DS_E1:   opnd = 27'(e1_r);
      DS_E2:   opnd = 27'(e2_r);
      DS_Y1:   opnd = 27'(y1_r);
      DS_Y2:   opnd = 27'(y2_r);
      // Floor shift of the sum by 16 is its upper bits.
      DS_V:    opnd = acc_r[42:16];
      default: opnd = '0;
    endcase
    term    = ctrl.word.neg ? -prod[42:0] : prod[42:0];
    acc_nxt = acc_r;
    if (ctrl.en) begin
      case (ctrl.word.op)
        OP_MAC:  acc_nxt = ctrl.word.first ? term : acc_r + term;
        OP_GAIN: acc_nxt = {{8{prod[50]}}, prod[50:16]};
        default: acc_nxt = acc_r;
      endcase
    end
  end

  // Clamp, history update, arming and the result word.
  always_comb begin
    lim = $signed({30'd0, cfg.output_limit});
    if (acc_r > lim) begin
      y = $signed({1'b0, cfg.output_limit});
    end else if (acc_r < -lim) begin
      y = -$signed({1'b0, cfg.output_limit});
    end else begin
      y = acc_r[13:0];
    end
    y_abs = y[13] ? 14'(-y) : 14'(y);
    over  = y_abs > SAT_THRESHOLD;

    commit    = ctrl.en && ctrl.word.op == OP_FINISH;
    e1_nxt    = e1_r;
    e2_nxt    = e2_r;
    y1_nxt    = y1_r;
    y2_nxt    = y2_r;
    cnt_nxt   = cnt_r;
    armed_nxt = armed_r;
    result.duty         = '0;
    result.motor_enable = 1'b0;
    result.disarm_cause = CAUSE_NONE;

    if (commit) begin
      case (path_r)
        PATH_PAUSE: begin
          armed_nxt           = 1'b0;
          result.disarm_cause = CAUSE_PAUSED;
        end
        PATH_ARM: begin
          e1_nxt    = '0;
          e2_nxt    = '0;
          y1_nxt    = '0;
          y2_nxt    = '0;
          armed_nxt = 1'b1;
        end
        PATH_TIP: begin
          armed_nxt           = 1'b0;
          result.disarm_cause = CAUSE_TIP;
        end
        PATH_DRIVE: begin
          if (FILTER_ORDER >= 2) begin
            e2_nxt = e1_r;
            y2_nxt = y1_r;
          end
          e1_nxt = e0_r;
          y1_nxt = y;
          // A stored count never exceeds the timeout, so reaching it while
          // still saturated is the timeout itself.
          if (over && cnt_r == CNT_MAX) begin
            cnt_nxt             = '0;
            armed_nxt           = 1'b0;
            result.disarm_cause = CAUSE_TIMEOUT;
          end else begin
            cnt_nxt             = over ? cnt_r + 1'b1 : '0;
            result.duty         = y;
            result.motor_enable = 1'b1;
          end
        end
        default: begin
          armed_nxt = armed_r;
        end
      endcase
    end
    result.armed_flag = armed_nxt;
  end

endmodule

// File: sim/balance_inner_loop_controller_test.sv
// Self-checking testbench for balance_inner_loop_controller: random valid/ready traffic
// on the input and output channels, a clocked predictor of the controller and a word-by-word check.
// Depends on blic_pkg and the controller RTL only.
module balance_inner_loop_controller_test;
  import blic_pkg::*;

  localparam int TAP_ORDER    = DEF_FILTER_ORDER;
  localparam int SAT_TICKS    = DEF_SAT_TIMEOUT_TICKS;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_WORDS = 900;

  typedef enum int {PH_DIRECTED, PH_RANDOM, PH_LOW_EXTREME, PH_HIGH_EXTREME,
                    PH_SATURATE} phase_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_tilt_angle = '0;
  logic signed [15:0] in_tilt_reference = '0;
  logic               in_running = 1'b0;
  logic               in_arm_request = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [13:0] out_duty;
  logic               out_motor_enable;
  logic               out_armed_flag;
  logic        [1:0]  out_disarm_cause;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [2:0]  cfg_index = '0;
  logic        [23:0] cfg_data = '0;

  in_item_t pending_samples[$];
  result_t  predicted_results[$];

  // Predictor state, mirrored from the block's registers.
  cfg_t    shadow_cfg;
  longint  err_tap[2];
  longint  out_tap[2];
  int      sat_run;
  bit      ctl_armed;

  int      fault_count = 0;
  int      words_checked = 0;
  bit      in_took = 1'b0;
  int      in_gap = 0;
  bit      in_burst = 1'b0;
  int      out_gap = 0;
  bit      out_burst = 1'b0;
  int      hold_left = 0;
  bit      hold_wanted = 1'b0;

  balance_inner_loop_controller u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_tilt_angle     (in_tilt_angle),
    .in_tilt_reference (in_tilt_reference),
    .in_running        (in_running),
    .in_arm_request    (in_arm_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty          (out_duty),
    .out_motor_enable  (out_motor_enable),
    .out_armed_flag    (out_armed_flag),
    .out_disarm_cause  (out_disarm_cause),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("balance_inner_loop_controller: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic load_register(input logic [2:0] idx, input logic [23:0] data);
    case (reg_idx_t'(idx))
      REG_NUM_B0:       shadow_cfg.num_b0       = data;
      REG_NUM_B1:       shadow_cfg.num_b1       = data;
      REG_NUM_B2:       shadow_cfg.num_b2       = data;
      REG_DEN_A1:       shadow_cfg.den_a1       = data;
      REG_DEN_A2:       shadow_cfg.den_a2       = data;
      REG_LOOP_GAIN:    shadow_cfg.loop_gain    = data;
      REG_OUTPUT_LIMIT: shadow_cfg.output_limit = data[12:0];
      REG_TILT_LIMIT:   shadow_cfg.tilt_limit   = data[13:0];
      default: ;
    endcase
  endtask

  function automatic result_t advance_controller(input in_item_t w);
    result_t r;
    longint  angle, reference, e0, acc, y, lim;
    angle     = longint'(w.tilt_angle);
    reference = longint'(w.tilt_reference);
    r.duty         = '0;
    r.motor_enable = 1'b0;
    r.disarm_cause = CAUSE_NONE;
    if (!w.running) begin
      if (ctl_armed) begin
        ctl_armed      = 1'b0;
        r.disarm_cause = CAUSE_PAUSED;
      end
    end else if (!ctl_armed) begin
      if (w.arm_request) begin
        err_tap   = '{0, 0};
        out_tap   = '{0, 0};
        ctl_armed = 1'b1;
      end
    end else if (((angle < 0) ? -angle : angle) > longint'(shadow_cfg.tilt_limit)) begin
      // Tip-over leaves the histories as they were.
      ctl_armed      = 1'b0;
      r.disarm_cause = CAUSE_TIP;
    end else begin
      e0 = reference - angle;
      if (e0 > 32767) e0 = 32767;
      if (e0 < -32768) e0 = -32768;
      acc = longint'(shadow_cfg.num_b0) * e0 + longint'(shadow_cfg.num_b1) * err_tap[0]
          - longint'(shadow_cfg.den_a1) * out_tap[0];
      if (TAP_ORDER >= 2)
        acc += longint'(shadow_cfg.num_b2) * err_tap[1]
             - longint'(shadow_cfg.den_a2) * out_tap[1];
      y   = ((acc >>> 16) * longint'(shadow_cfg.loop_gain)) >>> 16;
      lim = longint'(shadow_cfg.output_limit);
      if (y > lim) y = lim;
      if (y < -lim) y = -lim;
      if (TAP_ORDER >= 2) begin
        err_tap[1] = err_tap[0];
        out_tap[1] = out_tap[0];
      end
      err_tap[0] = e0;
      out_tap[0] = y;
      if (((y < 0) ? -y : y) > longint'(SAT_THRESHOLD)) begin
        if (sat_run <= SAT_TICKS) sat_run++;
      end else begin
        sat_run = 0;
      end
      if (sat_run > SAT_TICKS) begin
        // Saturation timeout: the histories have already taken y.
        ctl_armed      = 1'b0;
        sat_run        = 0;
        r.disarm_cause = CAUSE_TIMEOUT;
      end else begin
        r.duty         = y[13:0];
        r.motor_enable = 1'b1;
      end
    end
    r.armed_flag = ctl_armed;
    return r;
  endfunction

  // ------------------------------------------------------------------ checking

  task automatic report_mismatch(input string field, input int got, input int want);
    fault_count++;
    $display("ERROR word %0d %s: got %0d, want %0d", words_checked, field, got, want);
  endtask

  always @(posedge clk) begin
    in_item_t w;
    result_t  want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        w.tilt_angle     = in_tilt_angle;
        w.tilt_reference = in_tilt_reference;
        w.running        = in_running;
        w.arm_request    = in_arm_request;
        predicted_results.push_back(advance_controller(w));
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected word, duty", int'(out_duty), 0);
        end else begin
          want = predicted_results.pop_front();
          if (out_duty !== want.duty)
            report_mismatch("duty", int'(out_duty), int'(want.duty));
          if (out_motor_enable !== want.motor_enable)
            report_mismatch("motor_enable", int'(out_motor_enable), int'(want.motor_enable));
          if (out_armed_flag !== want.armed_flag)
            report_mismatch("armed_flag", int'(out_armed_flag), int'(want.armed_flag));
          if (out_disarm_cause !== want.disarm_cause)
            report_mismatch("disarm_cause", int'(out_disarm_cause), int'(want.disarm_cause));
        end
        words_checked++;
      end
    end
  end

  // ---------------------------------------------------------- driver, receiver

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(negedge clk) begin
    in_item_t w;
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        w = pending_samples.pop_front();
        in_tilt_angle     <= w.tilt_angle;
        in_tilt_reference <= w.tilt_reference;
        in_running        <= w.running;
        in_arm_request    <= w.arm_request;
        in_valid          <= 1'b1;
        if ($urandom_range(0, 99) < 3) in_burst = !in_burst;
        in_gap = pick_gap(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // A requested hold keeps ready low long enough for the block to back up
  // and refuse further input words.
  always @(negedge clk) begin
    if (hold_wanted && hold_left == 0) begin
      hold_left   = HOLD_CYCLES;
      hold_wanted = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 3) out_burst = !out_burst;
      if ($urandom_range(0, 3) == 0) out_gap = pick_gap(out_burst);
    end
  end

  // ------------------------------------------------------------------ stimulus

  function automatic in_item_t make_word(input int angle, input int reference,
                                         input bit run, input bit arm);
    in_item_t w;
    w.tilt_angle     = angle[15:0];
    w.tilt_reference = reference[15:0];
    w.running        = run;
    w.arm_request    = arm;
    return w;
  endfunction

  function automatic logic [23:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 24'h800000;
    if (r < 20) return 24'h7fffff;
    if (r < 30) return 24'h000000;
    if (r < 75) return 24'($urandom_range(0, 262143)) - 24'd131072;
    return 24'($urandom);
  endfunction

  function automatic int angle_within(input int tip);
    return $urandom_range(0, 2 * tip) - tip;
  endfunction

  function automatic int angle_beyond(input int tip);
    int mag;
    mag = $urandom_range(tip + 1, 32768);
    if (mag == 32768 || $urandom_range(0, 1)) return -mag;
    return mag;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic setup_phase(input phase_kind_t kind);
    logic [23:0] vals[8];
    case (kind)
      PH_DIRECTED: begin
        vals[REG_NUM_B0] = 24'd65536;
        vals[REG_NUM_B1] = -24'd32768;
        vals[REG_NUM_B2] = 24'd4096;
        vals[REG_DEN_A1] = 24'd16384;
        vals[REG_DEN_A2] = -24'd8192;
        vals[REG_LOOP_GAIN] = 24'd65536;
        vals[REG_OUTPUT_LIMIT] = 24'd4096;
        vals[REG_TILT_LIMIT] = 24'd3482;
      end
      PH_LOW_EXTREME: begin
        for (int i = 0; i < 6; i++) vals[i] = 24'h800000;
        vals[REG_OUTPUT_LIMIT] = 24'hffe000;
        vals[REG_TILT_LIMIT] = 24'hffc000;
      end
      PH_HIGH_EXTREME: begin
        for (int i = 0; i < 6; i++) vals[i] = 24'h7fffff;
        vals[REG_OUTPUT_LIMIT] = 24'h001fff;
        vals[REG_TILT_LIMIT] = 24'h003fff;
      end
      PH_SATURATE: begin
        vals[REG_NUM_B0] = 24'h7fffff;
        vals[REG_NUM_B1] = 24'h0;
        vals[REG_NUM_B2] = 24'h0;
        vals[REG_DEN_A1] = 24'h0;
        vals[REG_DEN_A2] = 24'h0;
        vals[REG_LOOP_GAIN] = 24'd65536;
        vals[REG_OUTPUT_LIMIT] = 24'd4096;
        vals[REG_TILT_LIMIT] = 24'd16383;
      end
      default: begin
        for (int i = 0; i < 6; i++) vals[i] = pick_coef();
        // Upper bits of the narrow registers carry noise that must be dropped.
        vals[REG_OUTPUT_LIMIT] = {11'($urandom),
          13'($urandom_range(0, 1) ? $urandom_range(3000, 8191) : $urandom_range(0, 8191))};
        vals[REG_TILT_LIMIT] = {10'($urandom),
          14'($urandom_range(0, 3) != 0 ? $urandom_range(1000, 12868)
                                        : $urandom_range(0, 16383))};
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), vals[i]);
  endtask

  // Mostly arm, drive for a while, then sometimes pause or tip over; some pure noise.
  task automatic fill_phase(input int n, input bit saturating, output int made);
    int tip, run_len, angle, reference, r;
    tip  = int'(shadow_cfg.tilt_limit);
    made = 0;
    while (made < n) begin
      if (!saturating && $urandom_range(0, 9) == 0) begin
        pending_samples.push_back(make_word($urandom, $urandom, 1'($urandom), 1'($urandom)));
        made++;
      end else begin
        pending_samples.push_back(make_word(angle_within(tip), $urandom, 1'b1, 1'b1));
        run_len = saturating ? $urandom_range(280, 320) : $urandom_range(1, 40);
        for (int i = 0; i < run_len; i++) begin
          angle = angle_within(tip);
          if (saturating)
            reference = angle + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(64, 16000);
          else if ($urandom_range(0, 1))
            reference = angle + $urandom_range(0, 400) - 200;
          else
            reference = $urandom;
          pending_samples.push_back(make_word(angle, reference, 1'b1, 1'($urandom)));
        end
        r = $urandom_range(0, 2);
        if (r == 0)
          pending_samples.push_back(make_word($urandom, $urandom, 1'b0, 1'($urandom)));
        else if (r == 1 && tip < 32768)
          pending_samples.push_back(make_word(angle_beyond(tip), $urandom, 1'b1,
                                              1'($urandom)));
        made += run_len + 2;
      end
    end
  endtask

  initial begin
    int total, made, phase_no;
    phase_kind_t kind;
    shadow_cfg = '{num_b0: '0, num_b1: '0, num_b2: '0, den_a1: '0, den_a2: '0,
                   loop_gain: RST_GAIN, output_limit: RST_LIMIT, tilt_limit: RST_TIP};
    err_tap   = '{0, 0};
    out_tap   = '{0, 0};
    sat_run   = 0;
    ctl_armed = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed words: pause and arm rules, error clamping, tip-over both ways.
    setup_phase(PH_DIRECTED);
    pending_samples.push_back(make_word(0, 0, 1'b0, 1'b1));
    pending_samples.push_back(make_word(0, 0, 1'b1, 1'b0));
    pending_samples.push_back(make_word(0, 0, 1'b1, 1'b1));
    pending_samples.push_back(make_word(100, -200, 1'b1, 1'b0));
    pending_samples.push_back(make_word(3482, -32768, 1'b1, 1'b1));
    pending_samples.push_back(make_word(-3482, 32767, 1'b1, 1'b0));
    pending_samples.push_back(make_word(0, 0, 1'b0, 1'b0));
    pending_samples.push_back(make_word(0, 0, 1'b0, 1'b1));
    pending_samples.push_back(make_word(0, 0, 1'b1, 1'b1));
    pending_samples.push_back(make_word(3483, 0, 1'b1, 1'b0));
    pending_samples.push_back(make_word(0, 0, 1'b1, 1'b1));
    pending_samples.push_back(make_word(-32768, 0, 1'b1, 1'b0));
    pending_samples.push_back(make_word(0, 0, 1'b1, 1'b1));
    pending_samples.push_back(make_word(32767, 0, 1'b1, 1'b0));
    pending_samples.push_back(make_word(0, 0, 1'b1, 1'b1));
    pending_samples.push_back(make_word(-1, -1, 1'b1, 1'b0));
    pending_samples.push_back(make_word(2000, -2000, 1'b1, 1'b0));
    pending_samples.push_back(make_word(-3483, 5, 1'b1, 1'b0));
    pending_samples.push_back(make_word(1, 2, 1'b1, 1'b1));
    pending_samples.push_back(make_word(1234, 4321, 1'b1, 1'b0));
    wait_quiet();

    total    = 0;
    phase_no = 0;
    while (total < RANDOM_WORDS) begin
      case (phase_no)
        2:       kind = PH_LOW_EXTREME;
        3:       kind = PH_SATURATE;
        4:       kind = PH_HIGH_EXTREME;
        default: kind = PH_RANDOM;
      endcase
      setup_phase(kind);
      fill_phase((kind == PH_SATURATE) ? 300 : $urandom_range(40, 120),
                 kind == PH_SATURATE, made);
      if (phase_no == 1 || kind == PH_SATURATE) hold_wanted = 1'b1;
      total += made;
      phase_no++;
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("balance_inner_loop_controller: match");
    end else begin
      $display("balance_inner_loop_controller: mismatch");
    end
    $finish;
  end

endmodule
